// ===== sv/whcp_pkg.sv =====
package whcp_pkg;

  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_RATE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_RATE     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_RATE     = 2'd2;

  localparam logic [31:0] DEFAULT_RATE_RST = 32'd16000;
  localparam logic [31:0] MIN_RATE_RST     = 32'd8000;
  localparam logic [31:0] MAX_RATE_RST     = 32'd48000;

  localparam logic [2:0] PH_HEADER    = 3'd0;
  localparam logic [2:0] PH_CHUNK_HDR = 3'd1;
  localparam logic [2:0] PH_FMT_BODY  = 3'd2;
  localparam logic [2:0] PH_SKIP      = 3'd3;
  localparam logic [2:0] PH_DONE      = 3'd4;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_BAD_HEADER = 2'd1;
  localparam logic [1:0] ST_NO_DATA    = 2'd2;
  localparam logic [1:0] ST_RATE       = 2'd3;

  localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
  localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
  localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
  localparam logic [31:0] TAG_DATA = 32'h6461_7461;

  localparam logic [4:0] FMT_TAKE_MAX = 5'd16;
  localparam logic [3:0] HDR_LAST_POS = 4'd11;
  localparam logic [3:0] CHDR_LAST_POS = 4'd7;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] sample_rate;
    logic [31:0] data_length;
  } result_t;

  typedef struct packed {
    logic [31:0] default_rate;
    logic [31:0] min_rate;
    logic [31:0] max_rate;
  } cfg_t;

endpackage

// ===== sv/whcp_if.sv =====
interface whcp_in_if;
  import whcp_pkg::*;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       first_byte;
  logic       last_byte;
  modport source (output valid, output data_byte, output first_byte, output last_byte,
                  input ready);
  modport sink (input valid, input data_byte, input first_byte, input last_byte,
                output ready);
endinterface

interface whcp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] sample_rate;
  logic [31:0] data_length;
  modport source (output valid, output status, output sample_rate, output data_length,
                  input ready);
  modport sink (input valid, input status, input sample_rate, input data_length,
                output ready);
endinterface

interface whcp_cfg_if;
  import whcp_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] wr_index;
  logic [31:0]          wr_data;
  modport source (output valid, output wr_index, output wr_data, input ready);
  modport sink (input valid, input wr_index, input wr_data, output ready);
endinterface

// ===== sv/whcp_cfg_regs.sv =====
module whcp_cfg_regs
  import whcp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  whcp_cfg_if.sink   cfg_s,
  output cfg_t       cfg
);

  cfg_t cfg_r;

  assign cfg_s.ready = 1'b1;
  assign cfg = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.default_rate <= DEFAULT_RATE_RST;
      cfg_r.min_rate     <= MIN_RATE_RST;
      cfg_r.max_rate     <= MAX_RATE_RST;
    end else if (cfg_s.valid) begin
      unique case (cfg_s.wr_index)
        CFG_DEFAULT_RATE: cfg_r.default_rate <= cfg_s.wr_data;
        CFG_MIN_RATE:     cfg_r.min_rate     <= cfg_s.wr_data;
        CFG_MAX_RATE:     cfg_r.max_rate     <= cfg_s.wr_data;
        default: ;
      endcase
    end
  end

endmodule

// ===== sv/whcp_parser.sv =====
module whcp_parser
  import whcp_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     step_en,
  input  in_item_t item,
  input  cfg_t     cfg,
  output logic     res_valid,
  output result_t  res
);

  logic [2:0]  phase_r, phase_nxt, cur_phase;
  logic [3:0]  bp_r, bp_nxt, cur_bp;
  logic        match_r, match_nxt, cur_match;
  logic [31:0] tag_r, tag_nxt, cur_tag;
  logic [31:0] len_r, len_nxt, cur_len;
  logic [32:0] skip_r, skip_nxt, cur_skip;
  logic [31:0] rate_r, rate_nxt, cur_rate;

  logic        emit;
  logic [1:0]  st;
  logic [4:0]  take;
  logic [4:0]  bp_inc;
  logic [7:0]  hdr_ref;
  logic [31:0] hdr_word;
  logic [31:0] fmt_rest;

  function automatic logic [4:0] fmt_take(input logic [31:0] len);
    fmt_take = (len < {27'd0, FMT_TAKE_MAX}) ? len[4:0] : FMT_TAKE_MAX;
  endfunction

  // restart folds in ahead of the step
  always_comb begin
    if (item.first_byte) begin
      cur_phase = PH_HEADER;
      cur_bp    = '0;
      cur_match = 1'b1;
      cur_tag   = '0;
      cur_len   = '0;
      cur_skip  = '0;
      cur_rate  = cfg.default_rate;
    end else begin
      cur_phase = phase_r;
      cur_bp    = bp_r;
      cur_match = match_r;
      cur_tag   = tag_r;
      cur_len   = len_r;
      cur_skip  = skip_r;
      cur_rate  = rate_r;
    end
  end

  assign hdr_word = (cur_bp < 4'd4) ? TAG_RIFF : TAG_WAVE;
  assign hdr_ref  = hdr_word[{~cur_bp[1:0], 3'b000} +: 8];
  assign bp_inc   = {1'b0, cur_bp} + 5'd1;

  always_comb begin
    phase_nxt = cur_phase;
    bp_nxt    = cur_bp;
    match_nxt = cur_match;
    tag_nxt   = cur_tag;
    len_nxt   = cur_len;
    skip_nxt  = cur_skip;
    rate_nxt  = cur_rate;
    emit      = 1'b0;
    st        = ST_OK;
    take      = fmt_take(cur_len);
    fmt_rest  = '0;

    unique case (cur_phase)
      PH_HEADER: begin
        if ((cur_bp < 4'd4 || cur_bp >= 4'd8) && item.data_byte != hdr_ref) begin
          match_nxt = 1'b0;
        end
        if (cur_bp >= HDR_LAST_POS) begin
          if (!match_nxt) begin
            emit = 1'b1;
            st   = ST_BAD_HEADER;
          end else begin
            phase_nxt = PH_CHUNK_HDR;
            bp_nxt    = '0;
          end
        end else begin
          bp_nxt = cur_bp + 4'd1;
        end
      end
      PH_CHUNK_HDR: begin
        if (cur_bp == 4'd0) begin
          tag_nxt = '0;
          len_nxt = '0;
        end
        if (cur_bp < 4'd4) begin
          tag_nxt = {tag_nxt[23:0], item.data_byte};
        end else begin
          len_nxt[{cur_bp[1:0], 3'b000} +: 8] = item.data_byte;
        end
        if (cur_bp >= CHDR_LAST_POS) begin
          bp_nxt = '0;
          take   = fmt_take(len_nxt);
          if (tag_nxt == TAG_FMT) begin
            rate_nxt = '0;
            if (take != 5'd0) begin
              phase_nxt = PH_FMT_BODY;
            end
          end else if (tag_nxt == TAG_DATA) begin
            emit = 1'b1;
            st   = (cur_rate < cfg.min_rate || cur_rate > cfg.max_rate) ? ST_RATE : ST_OK;
          end else begin
            skip_nxt = {1'b0, len_nxt} + {32'd0, len_nxt[0]};
            if (skip_nxt != '0) begin
              phase_nxt = PH_SKIP;
            end
          end
        end else begin
          bp_nxt = cur_bp + 4'd1;
        end
      end
      PH_FMT_BODY: begin
        if (cur_bp >= 4'd4 && cur_bp < 4'd8) begin
          rate_nxt[{cur_bp[1:0], 3'b000} +: 8] = item.data_byte;
        end
        if (bp_inc >= take) begin
          fmt_rest = cur_len - {27'd0, take};
          skip_nxt = {1'b0, fmt_rest};
          bp_nxt   = '0;
          phase_nxt = (fmt_rest != '0) ? PH_SKIP : PH_CHUNK_HDR;
        end else begin
          bp_nxt = bp_inc[3:0];
        end
      end
      PH_SKIP: begin
        if (cur_skip != '0) begin
          skip_nxt = cur_skip - 33'd1;
        end
        if (skip_nxt == '0) begin
          phase_nxt = PH_CHUNK_HDR;
          bp_nxt    = '0;
        end
      end
      default: ;
    endcase

    if (!emit && item.last_byte && cur_phase != PH_DONE) begin
      emit = 1'b1;
      st   = (phase_nxt == PH_HEADER) ? ST_BAD_HEADER : ST_NO_DATA;
    end
    if (emit) begin
      phase_nxt = PH_DONE;
    end
  end

  assign res_valid       = step_en && emit;
  assign res.status      = st;
  assign res.sample_rate = rate_nxt;
  assign res.data_length = (st == ST_OK) ? len_nxt : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HEADER;
      bp_r    <= '0;
      match_r <= 1'b1;
      tag_r   <= '0;
      len_r   <= '0;
      skip_r  <= '0;
      rate_r  <= DEFAULT_RATE_RST;
    end else if (step_en) begin
      phase_r <= phase_nxt;
      bp_r    <= bp_nxt;
      match_r <= match_nxt;
      tag_r   <= tag_nxt;
      len_r   <= len_nxt;
      skip_r  <= skip_nxt;
      rate_r  <= rate_nxt;
    end
  end

  a_done_after_result: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |=> phase_r == PH_DONE)
    else $error("parser not done after result");

  a_skip_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_SKIP |-> skip_r != '0)
    else $error("skip phase with zero count");

  a_hdr_pos: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_HEADER |-> bp_r <= HDR_LAST_POS)
    else $error("header position overrun");

  a_chdr_pos: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_CHUNK_HDR |-> bp_r <= CHDR_LAST_POS)
    else $error("chunk header position overrun");

endmodule

// ===== sv/wave_header_chunk_parser_unit.sv =====
// A byte that causes a result passes through the input register, then the parse logic
// into the result register, which drives the output.
// Throughput: one byte per cycle; the byte in the input register is parsed whenever
// the result register is empty or being drained.
// Reset (rst_n low, synchronous): parser back to header check, no item or result held,
// configuration registers to 16000 / 8000 / 48000.
module wave_header_chunk_parser_unit
  import whcp_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  whcp_in_if.sink      in_s,
  whcp_out_if.source   out_m,
  whcp_cfg_if.sink     cfg_s
);

  cfg_t     cfg;
  logic     in_valid_r;
  in_item_t in_item_r;
  logic     out_valid_r;
  result_t  out_res_r;
  logic     step_en;
  logic     res_valid;
  result_t  res;

  assign step_en    = in_valid_r && (!out_valid_r || out_m.ready);
  assign in_s.ready = !in_valid_r || step_en;

  whcp_cfg_regs u_cfg (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg_s (cfg_s),
    .cfg   (cfg)
  );

  whcp_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_en   (step_en),
    .item      (in_item_r),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_s.ready) begin
      in_valid_r <= in_s.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_s.ready && in_s.valid) begin
      in_item_r.data_byte  <= in_s.data_byte;
      in_item_r.first_byte <= in_s.first_byte;
      in_item_r.last_byte  <= in_s.last_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid) begin
      out_valid_r <= 1'b1;
    end else if (out_m.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_m.valid       = out_valid_r;
  assign out_m.status      = out_res_r.status;
  assign out_m.sample_rate = out_res_r.sample_rate;
  assign out_m.data_length = out_res_r.data_length;

  a_fail_zero_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_res_r.status == ST_OK || out_res_r.data_length == '0))
    else $error("failure result with nonzero length");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> (!out_valid_r || out_m.ready))
    else $error("result register overwritten");

endmodule
